/* src/pidc_pkg.sv */
// ---------------------------------------------------------------------------
// pidc_pkg: shared definitions for the clamped PID controller
// Field widths, derived datapath widths, register indexes and the status
// record that the serial arithmetic units report.
// ---------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

  // field widths
  localparam int DATA_WIDTH     = 16;  // error, gains, limits, output (Q8.8)
  localparam int INTEGRAL_WIDTH = 40;  // integrator (Q.24)
  localparam int STEP_W         = 16;  // step time (Q0.16)
  localparam int OUT_SHIFT      = 8;   // Q.16 sum -> Q8.8
  localparam int CFG_IDX_W      = 3;

  // multiplier: signed MA_W x signed MB_W, one multiplier bit per cycle
  localparam int MA_W = INTEGRAL_WIDTH;
  localparam int MB_W = ((DATA_WIDTH > STEP_W) ? DATA_WIDTH : STEP_W) + 1;
  localparam int MP_W = MA_W + MB_W;

  // divider: |diff| * 2^16 / step_time, one quotient bit per cycle
  localparam int DIFF_W = DATA_WIDTH + 1;
  localparam int NUM_W  = DATA_WIDTH + STEP_W;

  // Q.16 term accumulator
  localparam int SUM_W = INTEGRAL_WIDTH + DATA_WIDTH - STEP_W + 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OMAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OMIN = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, result valid and held
  } unit_stat_t;

endpackage

`default_nettype wire

/* src/pidc_mul.sv */
// ---------------------------------------------------------------------------
// pidc_mul: bit-serial signed multiplier
// Right-shifting shift-add: one multiplier bit per cycle, top bit subtracts.
// ---------------------------------------------------------------------------
`default_nettype none

module pidc_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [pidc_pkg::MA_W-1:0]   a,
  input  logic signed [pidc_pkg::MB_W-1:0]   b,
  output pidc_pkg::unit_stat_t               stat,
  output logic signed [pidc_pkg::MP_W-1:0]   p
);

  localparam int MA_W   = pidc_pkg::MA_W;
  localparam int MB_W   = pidc_pkg::MB_W;
  localparam int MCNT_W = $clog2(MB_W + 1);

  logic signed [MA_W-1:0] a_r, a_nxt;
  logic signed [MA_W:0]   hi_r, hi_nxt;
  logic [MB_W-1:0]        lo_r, lo_nxt;
  logic [MCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;

  logic signed [MA_W:0]   a_ext;
  logic signed [MA_W:0]   addend;
  logic signed [MA_W:0]   sum;
  logic                   last;

  always_comb begin
    a_ext  = {a_r[MA_W-1], a_r};
    last   = (cnt_r == MCNT_W'(1));
    addend = '0;
    if (lo_r[0]) begin
      addend = last ? -a_ext : a_ext;
    end
    sum = hi_r + addend;

    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      hi_nxt   = '0;
      lo_nxt   = b;
      cnt_nxt  = MCNT_W'(MB_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = {sum[MA_W], sum[MA_W:1]};
      lo_nxt  = {sum[0], lo_r[MB_W-1:1]};
      cnt_nxt = cnt_r - MCNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign p         = {hi_r[MA_W-1:0], lo_r};

endmodule

`default_nettype wire

/* src/pidc_div.sv */
// ---------------------------------------------------------------------------
// pidc_div: bit-serial unsigned restoring divider
// Numerator shifts out MSB first; one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module pidc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [pidc_pkg::NUM_W-1:0]      num,
  input  logic [pidc_pkg::STEP_W-1:0]     den,
  output pidc_pkg::unit_stat_t            stat,
  output logic [pidc_pkg::NUM_W-1:0]      quo
);

  localparam int NUM_W  = pidc_pkg::NUM_W;
  localparam int DEN_W  = pidc_pkg::STEP_W;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  trial;
  logic              ge;

  always_comb begin
    shifted = {rem_r, num_r[NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_r};
    ge      = ~trial[DEN_W+1];

    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = DCNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      rem_nxt = ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

`default_nettype wire

/* src/pid_controller_clamped_top.sv */
// ---------------------------------------------------------------------------
// pid_controller_clamped_top: discrete PID controller with output clamp
// Saturating integrator, derivative by serial divide, Q8.8 output clamped
// to programmable limits. Two bit-serial multipliers and one bit-serial
// divider do all the arithmetic.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ------------------------------
//  in_      sink       in_valid / in_stall   in_error_in, in_step_time
//  out_     source     out_valid / out_stall out_control_out
//  cfg_     sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One request at a time: the block takes no new item until it is back in
//  idle. The three serial multiply passes (e*dt with kp*e, ki*I, kd*D) on
//  MB_W = 17 multiplier bits run in turn and set the time per item;
//  the 32-step divide runs beside the first two passes.
//  Reset (rst_n low, synchronous) clears gains to 0, limits to full range,
//  the integrator and previous error to 0, and arms the first-sample flag.
//  A stalled result sits in the output register; the next item is accepted
//  meanwhile and waits in its final state until the register frees up.
//  cfg_ready is always high; unknown register indexes are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input requests
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [pidc_pkg::DATA_WIDTH-1:0] in_error_in,
  input  logic [pidc_pkg::STEP_W-1:0]            in_step_time,
  // results
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pidc_pkg::DATA_WIDTH-1:0] out_control_out,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pidc_pkg::DATA_WIDTH-1:0]        cfg_data
);

  localparam int DW     = pidc_pkg::DATA_WIDTH;
  localparam int IW     = pidc_pkg::INTEGRAL_WIDTH;
  localparam int SW     = pidc_pkg::STEP_W;
  localparam int MA_W   = pidc_pkg::MA_W;
  localparam int MB_W   = pidc_pkg::MB_W;
  localparam int MP_W   = pidc_pkg::MP_W;
  localparam int NUM_W  = pidc_pkg::NUM_W;
  localparam int DIFF_W = pidc_pkg::DIFF_W;
  localparam int SUM_W  = pidc_pkg::SUM_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a request
  localparam logic [2:0] S_LAUNCH = 3'd1;  // start divide, e*dt, kp*e
  localparam logic [2:0] S_INT    = 3'd2;  // integrator update, kp term
  localparam logic [2:0] S_KI     = 3'd3;  // start ki*I
  localparam logic [2:0] S_KIW    = 3'd4;  // add ki term
  localparam logic [2:0] S_KD     = 3'd5;  // start kd*D once divide is done
  localparam logic [2:0] S_KDW    = 3'd6;  // add kd term
  localparam logic [2:0] S_OUT    = 3'd7;  // clamp, load output register

  // configuration
  logic signed [DW-1:0] kp_r, kp_nxt;
  logic signed [DW-1:0] ki_r, ki_nxt;
  logic signed [DW-1:0] kd_r, kd_nxt;
  logic signed [DW-1:0] omax_r, omax_nxt;
  logic signed [DW-1:0] omin_r, omin_nxt;

  // controller state
  logic [2:0]             state_r, state_nxt;
  logic                   first_r, first_nxt;
  logic signed [DW-1:0]   prev_r, prev_nxt;
  logic signed [IW-1:0]   integral_r, integral_nxt;

  // per-item working registers (payload)
  logic signed [DW-1:0]     e_r, e_nxt;
  logic [SW-1:0]            dt_r, dt_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_data_r, out_data_nxt;

  // arithmetic units
  pidc_pkg::unit_stat_t     mul0_stat, mul1_stat, div_stat;
  logic                     mul0_start, mul1_start, div_start;
  logic signed [MA_W-1:0]   mul0_a, mul1_a;
  logic signed [MB_W-1:0]   mul0_b, mul1_b;
  logic signed [MP_W-1:0]   mul0_p, mul1_p;
  logic [NUM_W-1:0]         div_num, div_quo;

  // combinational helpers
  logic                     in_acc, out_acc, can_load;
  logic signed [DW-1:0]     prev_eff;
  logic signed [DIFF_W-1:0] diff_mag;
  logic signed [DW-1:0]     d_val;
  logic                     q_over_pos, q_over_neg;
  logic signed [IW:0]       isum;
  logic signed [IW-1:0]     isat;
  logic signed [MP_W-1:0]   ki_sh;
  logic signed [SUM_W-1:0]  y;
  logic signed [SUM_W-1:0]  omax_ext, omin_ext;
  logic signed [DW-1:0]     y_clamped;

  assign in_acc    = in_valid & ~in_stall;
  assign out_acc   = out_valid_r & ~out_stall;
  assign can_load  = ~out_valid_r | ~out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // derivative numerator: |e - prev| * 2^16
  assign prev_eff = first_r ? in_error_in : prev_r;
  assign diff_mag = diff_r[DIFF_W-1] ? -diff_r : diff_r;
  assign div_num  = {diff_mag[DW-1:0], {SW{1'b0}}};

  // quotient -> saturated signed derivative; zero step time forces zero
  assign q_over_pos = |div_quo[NUM_W-1:DW-1];
  assign q_over_neg = (|div_quo[NUM_W-1:DW]) | (div_quo[DW-1] & (|div_quo[DW-2:0]));
  always_comb begin
    if (dt_r == '0) begin
      d_val = '0;
    end else if (!diff_r[DIFF_W-1]) begin
      d_val = q_over_pos ? {1'b0, {(DW-1){1'b1}}} : div_quo[DW-1:0];
    end else begin
      d_val = q_over_neg ? {1'b1, {(DW-1){1'b0}}} : -div_quo[DW-1:0];
    end
  end

  // saturating integrator add (e*dt fits well inside IW+1 bits)
  assign isum = {integral_r[IW-1], integral_r} + mul0_p[IW:0];
  always_comb begin
    if (isum[IW] != isum[IW-1]) begin
      isat = isum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      isat = isum[IW-1:0];
    end
  end

  // floor(ki*I / 2^16)
  assign ki_sh = mul0_p >>> SW;

  // Q.16 -> Q8.8 floor, then clamp; upper limit is tested first, so it wins when y exceeds both
  assign y        = acc_r >>> pidc_pkg::OUT_SHIFT;
  assign omax_ext = {{(SUM_W-DW){omax_r[DW-1]}}, omax_r};
  assign omin_ext = {{(SUM_W-DW){omin_r[DW-1]}}, omin_r};
  always_comb begin
    if (y > omax_ext) begin
      y_clamped = omax_r;
    end else if (y < omin_ext) begin
      y_clamped = omin_r;
    end else begin
      y_clamped = y[DW-1:0];
    end
  end

  // unit operand select
  always_comb begin
    mul0_start = (state_r == S_LAUNCH) | (state_r == S_KI);
    mul1_start = (state_r == S_LAUNCH) | ((state_r == S_KD) & ~div_stat.busy);
    div_start  = (state_r == S_LAUNCH);
    if (state_r == S_LAUNCH) begin
      mul0_a = {{(MA_W-DW){e_r[DW-1]}}, e_r};
      mul0_b = {{(MB_W-SW){1'b0}}, dt_r};
      mul1_a = {{(MA_W-DW){e_r[DW-1]}}, e_r};
      mul1_b = {{(MB_W-DW){kp_r[DW-1]}}, kp_r};
    end else begin
      mul0_a = integral_r;
      mul0_b = {{(MB_W-DW){ki_r[DW-1]}}, ki_r};
      mul1_a = {{(MA_W-DW){d_val[DW-1]}}, d_val};
      mul1_b = {{(MB_W-DW){kd_r[DW-1]}}, kd_r};
    end
  end

  pidc_mul u_mul0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul0_start),
    .a     (mul0_a),
    .b     (mul0_b),
    .stat  (mul0_stat),
    .p     (mul0_p)
  );

  pidc_mul u_mul1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul1_start),
    .a     (mul1_a),
    .b     (mul1_b),
    .stat  (mul1_stat),
    .p     (mul1_p)
  );

  pidc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dt_r),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // configuration writes
  always_comb begin
    kp_nxt   = kp_r;
    ki_nxt   = ki_r;
    kd_nxt   = kd_r;
    omax_nxt = omax_r;
    omin_nxt = omin_r;
    if (cfg_valid) begin
      case (cfg_index)
        pidc_pkg::REG_KP:   kp_nxt   = cfg_data;
        pidc_pkg::REG_KI:   ki_nxt   = cfg_data;
        pidc_pkg::REG_KD:   kd_nxt   = cfg_data;
        pidc_pkg::REG_OMAX: omax_nxt = cfg_data;
        pidc_pkg::REG_OMIN: omin_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    integral_nxt  = integral_r;
    e_nxt         = e_r;
    dt_nxt        = dt_r;
    diff_nxt      = diff_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r & ~out_acc;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          e_nxt     = in_error_in;
          dt_nxt    = in_step_time;
          diff_nxt  = {in_error_in[DW-1], in_error_in} - {prev_eff[DW-1], prev_eff};
          prev_nxt  = in_error_in;
          first_nxt = 1'b0;
          state_nxt = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        state_nxt = S_INT;
      end
      S_INT: begin
        if (mul0_stat.done) begin
          integral_nxt = isat;
          acc_nxt      = mul1_p[SUM_W-1:0];
          state_nxt    = S_KI;
        end
      end
      S_KI: begin
        state_nxt = S_KIW;
      end
      S_KIW: begin
        if (mul0_stat.done) begin
          acc_nxt   = acc_r + ki_sh[SUM_W-1:0];
          state_nxt = S_KD;
        end
      end
      S_KD: begin
        if (!div_stat.busy) begin
          state_nxt = S_KDW;
        end
      end
      S_KDW: begin
        if (mul1_stat.done) begin
          acc_nxt   = acc_r + mul1_p[SUM_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = y_clamped;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      omax_r      <= {1'b0, {(DW-1){1'b1}}};
      omin_r      <= {1'b1, {(DW-1){1'b0}}};
      state_r     <= S_IDLE;
      first_r     <= 1'b1;
      prev_r      <= '0;
      integral_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      kp_r        <= kp_nxt;
      ki_r        <= ki_nxt;
      kd_r        <= kd_nxt;
      omax_r      <= omax_nxt;
      omin_r      <= omin_nxt;
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      prev_r      <= prev_nxt;
      integral_r  <= integral_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    dt_r       <= dt_nxt;
    diff_r     <= diff_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_control_out = out_data_r;

`ifndef SYNTH
  // both multipliers start together at launch and must finish together
  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INT && mul0_stat.done) |-> mul1_stat.done)
    else $error("multiplier pair out of step at integrator update");

  // any accepted request retires the first-sample flag
  a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !first_r)
    else $error("first-sample flag still set after a request");

  // integrator only moves during the update step of an item
  a_int_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> $stable(integral_r))
    else $error("integrator changed while idle");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_pid_controller_clamped_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pid_controller_clamped_top: self-checking bench for the clamped PID
// Drives error/step-time requests and register writes into the controller,
// predicts each clamped control drive in a small scoreboard, and compares
// every result in order. Both sides idle and stall at random.
// ---------------------------------------------------------------------------

module tb_pid_controller_clamped_top;

  typedef logic signed [pidc_pkg::DATA_WIDTH-1:0] q88_t;
  typedef logic [pidc_pkg::STEP_W-1:0]            step_t;
  typedef logic [pidc_pkg::CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic [pidc_pkg::DATA_WIDTH-1:0]        cfg_word_t;

  localparam longint Q88_MAX = (longint'(1) << (pidc_pkg::DATA_WIDTH - 1)) - 1;
  localparam longint Q88_MIN = -Q88_MAX - 1;
  localparam longint ACC_MAX = (longint'(1) << (pidc_pkg::INTEGRAL_WIDTH - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  // watchdog: cycles in a row with no handshake on any channel
  localparam int STALL_LIMIT = 5000;
  // receiver hold-off used to back the block up into its input
  localparam int HOLD_CYCLES = 800;
  localparam int HOLD_AFTER  = 120;
  // settle time after the last result
  localparam int SETTLE      = 64;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  q88_t      in_error_in;
  step_t     in_step_time;
  logic      out_valid;
  logic      out_stall;
  q88_t      out_control_out;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_idx_t  cfg_index;
  cfg_word_t cfg_data;

  int samples_sent;

  pid_controller_clamped_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_error_in     (in_error_in),
    .in_step_time    (in_step_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_control_out (out_control_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // -------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of gains, limits and loop state, works out
  // the control drive for every accepted request and checks results in order.
  // -------------------------------------------------------------------------
  class pid_scoreboard;
    longint kp, ki, kd, lim_hi, lim_lo;
    longint last_err;       // previous error sample
    longint integ;          // Q.24 integrator, saturates at INTEGRAL_WIDTH
    bit     first_pending;
    q88_t   drive_q[$];     // predicted control drives, oldest first
    int     errors;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      lim_hi = Q88_MAX;
      lim_lo = Q88_MIN;
      last_err = 0;
      integ = 0;
      first_pending = 1'b1;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, cfg_word_t data);
      longint v;
      v = longint'($signed(data));
      case (idx)
        pidc_pkg::REG_KP:   kp = v;
        pidc_pkg::REG_KI:   ki = v;
        pidc_pkg::REG_KD:   kd = v;
        pidc_pkg::REG_OMAX: lim_hi = v;
        pidc_pkg::REG_OMIN: lim_lo = v;
        default: ;  // unknown index, dropped by the block
      endcase
    endfunction

    function void note_sample(q88_t err, step_t dt);
      longint e, t, deriv, prod, ihi, ilo, total, y;
      e = err;
      t = dt;
      // first sample after reset: no history, so no derivative kick
      if (first_pending) begin
        last_err = e;
        first_pending = 1'b0;
      end
      // derivative in Q8.8, quotient truncated toward zero, zero when dt is 0
      deriv = 0;
      if (t != 0) begin
        deriv = ((e - last_err) * 65536) / t;
        if (deriv > Q88_MAX) deriv = Q88_MAX;
        else if (deriv < Q88_MIN) deriv = Q88_MIN;
      end
      last_err = e;
      // integrator, e*dt in Q.24 with saturation
      prod = e * t;
      if (integ + prod > ACC_MAX) integ = ACC_MAX;
      else if (integ + prod < ACC_MIN) integ = ACC_MIN;
      else integ = integ + prod;
      // ki*I split into high and low halves, each floored back to Q.16;
      // all products stay far below the 2^61 term cap at these widths
      ihi = integ >>> 16;
      ilo = integ & 64'hFFFF;
      total = kp * e + ki * ihi + ((ki * ilo) >>> 16) + kd * deriv;
      y = total >>> pidc_pkg::OUT_SHIFT;
      // upper limit is tested first, so it wins when y exceeds both limits
      if (y > lim_hi) y = lim_hi;
      else if (y < lim_lo) y = lim_lo;
      drive_q.push_back(q88_t'(y));
    endfunction

    function void check_drive(q88_t got);
      q88_t want;
      if (drive_q.size() == 0) begin
        errors++;
        $error("control_out: expected none pending, actual %0d", got);
      end else begin
        want = drive_q.pop_front();
        if (got !== want) begin
          errors++;
          $error("control_out: expected %0d, actual %0d", want, got);
        end
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction

    function void flush_check();
      if (drive_q.size() != 0) begin
        errors += drive_q.size();
        $error("control_out: expected %0d more results (next %0d), actual none",
               drive_q.size(), drive_q[0]);
      end
    endfunction
  endclass

  pid_scoreboard sb = new();

  // -------------------------------------------------------------------------
  // Clock
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Monitor: samples pre-edge values of all three channels. Config writes
  // and requests never share an edge, so the order here does not matter.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_sample(in_error_in, in_step_time);
      if (out_valid && !out_stall) sb.check_drive(out_control_out);
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: any handshake resets the idle count
  // -------------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $error("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("[pid_controller_clamped_top] ERROR");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Result side: random stall/free stretches of mixed length, plus one long
  // hold-off once traffic is flowing so the block backs up into in_stall.
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int  span;
    bit  hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && samples_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin  // free-running stretch
            out_stall <= 1'b0;
            span = $urandom_range(100, 400);
          end
          2: begin
            out_stall <= 1'b1;
            span = $urandom_range(71, 250);
          end
          3, 4: begin
            out_stall <= 1'b1;
            span = $urandom_range(9, 70);
          end
          5, 6: begin
            out_stall <= 1'b1;
            span = $urandom_range(1, 8);
          end
          default: begin
            out_stall <= 1'b0;
            span = $urandom_range(1, 80);
          end
        endcase
        repeat (span) @(posedge clk);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // errors: rails, values near zero, otherwise anything
  function automatic q88_t rand_error();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? q88_t'(16'h7FFF) : q88_t'(16'h8000);
      1:       return q88_t'(int'($urandom_range(0, 600)) - 300);
      default: return q88_t'($urandom);
    endcase
  endfunction

  // step times: zero (no integral, no derivative), tiny (derivative
  // saturation), full scale, otherwise anything
  function automatic step_t rand_step();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return step_t'($urandom_range(1, 16));
      2:       return '1;
      default: return step_t'($urandom);
    endcase
  endfunction

  // sender gap after a request: mostly none or short, a few long
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(60, 200);
  endfunction

  // one request; valid stays up when no gap follows
  task automatic send_sample(input q88_t err, input step_t dt, input int gap);
    in_valid     <= 1'b1;
    in_error_in  <= err;
    in_step_time <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_word_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // full register set, plus a write to an index past the list that the
  // block must drop
  task automatic configure(input q88_t kp, input q88_t ki, input q88_t kd,
                           input q88_t hi, input q88_t lo);
    write_reg(pidc_pkg::REG_KP, kp);
    write_reg(pidc_pkg::REG_KI, ki);
    write_reg(pidc_pkg::REG_KD, kd);
    write_reg(pidc_pkg::REG_OMAX, hi);
    write_reg(pidc_pkg::REG_OMIN, lo);
    write_reg(cfg_idx_t'($urandom_range(pidc_pkg::REG_OMIN + 1,
                                        (1 << pidc_pkg::CFG_IDX_W) - 1)),
              cfg_word_t'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // stop offering, let every result drain, then let the pipe settle so the
  // next register writes land on an idle block
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    q88_t  err;
    step_t dt;

    samples_sent = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_error_in  <= '0;
    in_step_time <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unity kp, small ki/kd, full-range limits
    configure(16'sh0100, 16'sh0040, 16'sh0008, 16'sh7FFF, 16'sh8000);
    send_sample(16'sd100, 16'd256, 0);      // first sample, derivative forced to 0
    send_sample(-16'sd32768, 16'd1, 0);     // huge negative slope, derivative rails low
    send_sample(16'sd32767, 16'd1, 3);      // huge positive slope, rails high
    send_sample(16'sd32767, 16'd0, 0);      // zero step: no D, integral holds
    send_sample(-16'sd32768, 16'd0, 0);
    send_sample(16'sd0, 16'hFFFF, 1);
    send_sample(-16'sd32768, 16'hFFFF, 0);
    send_sample(16'sd32767, 16'hFFFF, 0);
    send_sample(-16'sd1, 16'd1, 0);
    send_sample(16'sd1, 16'd3, 0);          // positive slope, derivative rails high
    send_sample(-16'sd1, 16'd3, 0);         // negative slope, derivative rails low
    send_sample(16'sd0, 16'd0, 0);
    send_sample(16'sd256, 16'h8000, 0);
    send_sample(-16'sd256, 16'd1, 0);
    drain();

    // directed: inverted limits, upper limit is tested first
    configure(16'sh0200, 16'sh0000, 16'sh0004, -16'sd1000, 16'sd1000);
    send_sample(16'sd32767, 16'd100, 0);
    send_sample(-16'sd32768, 16'd100, 0);
    send_sample(16'sd0, 16'd0, 0);
    send_sample(16'sd10, 16'd0, 2);
    send_sample(-16'sd10, 16'd0, 0);
    drain();

    // random registers and random requests
    configure(q88_t'($urandom), q88_t'($urandom), q88_t'($urandom),
              q88_t'($urandom), q88_t'($urandom));
    for (int i = 0; i < 60; i++) send_sample(rand_error(), rand_step(), rand_gap());
    drain();

    // positive windup with ki = 1, so the drive tracks I / 2^24 directly and
    // the integrator reaches its upper rail; no sender gaps here
    configure(16'sh0000, 16'sh0001, 16'sh0000, 16'sh7FFF, 16'sh8000);
    for (int i = 0; i < 320; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        err = rand_error();
        dt  = rand_step();
      end else begin
        err = q88_t'($urandom_range(30000, 32767));
        dt  = step_t'($urandom_range(60000, 65535));
      end
      send_sample(err, dt, 0);
    end
    drain();

    // negative windup all the way to the lower rail
    configure(16'sh0001, 16'sh0001, 16'sh0001, 16'sd20000, 16'sh8000);
    for (int i = 0; i < 600; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        err = rand_error();
        dt  = rand_step();
      end else begin
        err = q88_t'(-int'($urandom_range(30000, 32768)));
        dt  = step_t'($urandom_range(60000, 65535));
      end
      send_sample(err, dt, rand_gap());
    end
    drain();

    // extreme gains, full-range limits
    configure(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    for (int i = 0; i < 45; i++) send_sample(rand_error(), rand_step(), rand_gap());
    drain();

    // opposite extreme gains, fully inverted limits
    configure(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
    for (int i = 0; i < 45; i++) send_sample(rand_error(), rand_step(), rand_gap());
    drain();

    // drain() already waited out the latency; catch any stray result
    repeat (2 * SETTLE) @(posedge clk);
    sb.flush_check();
    if (sb.errors == 0)
      $display("[pid_controller_clamped_top] OK");
    else
      $display("[pid_controller_clamped_top] ERROR");
    $finish;
  end

endmodule
